// ===== hdl/strict_utf8_decoder_top_macros.svh =====
// assertion macros used by the su8d_decode module
`ifndef STRICT_UTF8_DECODER_TOP_MACROS_SVH
`define STRICT_UTF8_DECODER_TOP_MACROS_SVH

// implication in the same cycle
`define SU8D_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle
`define SU8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/su8d_pkg.sv =====
`timescale 1ns / 1ps

package su8d_pkg;

    localparam int unsigned CP_W = 21;

    // byte classes
    localparam logic [7:0] ASCII_MAX = 8'h7f;
    localparam logic [7:0] LEAD2_MIN = 8'hc2;
    localparam logic [7:0] LEAD2_MAX = 8'hdf;
    localparam logic [7:0] LEAD3_MIN = 8'he0;
    localparam logic [7:0] LEAD4_MIN = 8'hf0;
    localparam logic [7:0] LEAD4_MAX = 8'hf4;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // sequence lengths
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // scalar value limits
    localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR  = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00dfff;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10ffff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic            has_point;
        logic [CP_W-1:0] code_point;
        logic            end_of_text;
        logic            text_ok;
    } t_result;

    // rejects overlong forms, surrogates and values beyond the last plane
    function automatic logic point_ok(input logic [2:0] len, input logic [CP_W-1:0] p);
        logic ok;
        ok = 1'b1;
        if (len == SEQ_THREE && p < MIN_THREE) ok = 1'b0;
        if (len == SEQ_FOUR && p < MIN_FOUR) ok = 1'b0;
        if (p >= SURR_LO && p <= SURR_HI) ok = 1'b0;
        if (p > CP_MAX) ok = 1'b0;
        return ok;
    endfunction

endpackage

// ===== hdl/strict_utf8_decoder_top.sv =====
// strict utf-8 decoder, one byte per item
// a byte waits in the input register and is decoded when the result register
//   has room; any result item it gives is registered there
// throughput: 1 byte per cycle unless the output stalls; the decode step
//   between input and result registers updates the sequence state once per byte
// reset: synchronous active low, empties both registers and clears decoder state
`timescale 1ns / 1ps

module strict_utf8_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_has_point,
    output logic [20:0] o_code_point,
    output logic        o_end_of_text,
    output logic        o_text_ok
);

    su8d_pkg::t_item   w_in_item;
    su8d_pkg::t_item   w_held_item;
    su8d_pkg::t_result w_dec_result;
    su8d_pkg::t_result w_out_result;
    logic              w_held_valid;
    logic              w_can_take;
    logic              w_fire;
    logic              w_emit;

    assign w_in_item.data_byte  = i_data_byte;
    assign w_in_item.final_byte = i_final_byte;

    // a held item is decoded when the result register has room
    assign w_fire = w_held_valid && w_can_take;

    su8d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (w_in_item),
        .i_take  (w_fire),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    su8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_held_item),
        .o_emit   (w_emit),
        .o_result (w_dec_result)
    );

    su8d_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire && w_emit),
        .i_result   (w_dec_result),
        .o_can_take (w_can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (w_out_result)
    );

    assign o_has_point   = w_out_result.has_point;
    assign o_code_point  = w_out_result.code_point;
    assign o_end_of_text = w_out_result.end_of_text;
    assign o_text_ok     = w_out_result.text_ok;

endmodule

// ===== hdl/su8d_in_reg.sv =====
`timescale 1ns / 1ps

module su8d_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  su8d_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output su8d_pkg::t_item o_item
);

    logic            r_valid;
    su8d_pkg::t_item r_item;

    // room when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // held item
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/su8d_decode.sv =====
`timescale 1ns / 1ps
`include "strict_utf8_decoder_top_macros.svh"

module su8d_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  su8d_pkg::t_item  i_item,
    output logic             o_emit,
    output su8d_pkg::t_result o_result
);

    logic [1:0]                r_pending, n_pending;
    logic [2:0]                r_len, n_len;
    logic [su8d_pkg::CP_W-1:0] r_partial, n_partial;
    logic                      r_failed, n_failed;
    logic                      w_hp;
    logic [su8d_pkg::CP_W-1:0] w_cp;
    logic [su8d_pkg::CP_W-1:0] w_shifted;
    logic [7:0]                w_b;

    assign w_b       = i_item.data_byte;
    assign w_shifted = {r_partial[su8d_pkg::CP_W-7:0], w_b[5:0]};

    // byte decode and state update
    always_comb begin
        n_pending = r_pending;
        n_len     = r_len;
        n_partial = r_partial;
        n_failed  = r_failed;
        w_hp      = 1'b0;
        w_cp      = '0;
        if (!r_failed) begin
            if (r_pending == 2'd0) begin
                if (w_b == 8'h00) begin
                    n_failed = 1'b1;
                end else if (w_b <= su8d_pkg::ASCII_MAX) begin
                    w_hp = 1'b1;
                    w_cp = {13'd0, w_b};
                end else if (w_b >= su8d_pkg::LEAD2_MIN && w_b <= su8d_pkg::LEAD2_MAX) begin
                    n_pending = 2'd1;
                    n_len     = su8d_pkg::SEQ_TWO;
                    n_partial = {16'd0, w_b[4:0]};
                end else if (w_b >= su8d_pkg::LEAD3_MIN && w_b < su8d_pkg::LEAD4_MIN) begin
                    n_pending = 2'd2;
                    n_len     = su8d_pkg::SEQ_THREE;
                    n_partial = {17'd0, w_b[3:0]};
                end else if (w_b >= su8d_pkg::LEAD4_MIN && w_b <= su8d_pkg::LEAD4_MAX) begin
                    n_pending = 2'd3;
                    n_len     = su8d_pkg::SEQ_FOUR;
                    n_partial = {18'd0, w_b[2:0]};
                end else begin
                    n_failed = 1'b1;
                end
            end else begin
                if (w_b[7:6] != su8d_pkg::CONT_TAG) begin
                    n_failed = 1'b1;
                end else begin
                    n_partial = w_shifted;
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        if (su8d_pkg::point_ok(r_len, w_shifted)) begin
                            w_hp = 1'b1;
                            w_cp = w_shifted;
                        end else begin
                            n_failed = 1'b1;
                        end
                        n_len     = su8d_pkg::SEQ_NONE;
                        n_partial = '0;
                    end
                end
            end
        end

        // end of text: a cut-off sequence fails, then all state clears
        o_result.has_point   = w_hp;
        o_result.code_point  = w_cp;
        o_result.end_of_text = i_item.final_byte;
        o_result.text_ok     = 1'b0;
        if (i_item.final_byte) begin
            if (n_pending != 2'd0) n_failed = 1'b1;
            o_result.text_ok = !n_failed;
            n_pending = 2'd0;
            n_len     = su8d_pkg::SEQ_NONE;
            n_partial = '0;
            n_failed  = 1'b0;
        end
        o_emit = i_item.final_byte || w_hp;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_len     <= su8d_pkg::SEQ_NONE;
            r_partial <= '0;
            r_failed  <= 1'b0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_len     <= n_len;
            r_partial <= n_partial;
            r_failed  <= n_failed;
        end
    end

    // checks
    `SU8D_ASSERT_IMPL(a_mid_text_has_point, i_clk, i_rst_n,
        i_fire && o_emit && !o_result.end_of_text, o_result.has_point,
        "mid-text item emitted without a point")
    `SU8D_ASSERT_IMPL(a_empty_point_zero, i_clk, i_rst_n,
        !o_result.has_point, o_result.code_point == '0,
        "code point not zero without a point")
    `SU8D_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n,
        i_fire && i_item.final_byte,
        r_pending == 2'd0 && !r_failed && r_partial == '0,
        "state not cleared after final byte")
    `SU8D_ASSERT_IMPL(a_failed_silent, i_clk, i_rst_n,
        i_fire && r_failed && !i_item.final_byte, !o_emit,
        "failed text still emitting")

endmodule

// ===== hdl/su8d_out_reg.sv =====
`timescale 1ns / 1ps

module su8d_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  su8d_pkg::t_result i_result,
    output logic              o_can_take,
    output logic              o_valid,
    input  logic              i_ready,
    output su8d_pkg::t_result o_result
);

    logic              r_valid;
    su8d_pkg::t_result r_result;

    // free when empty or drained this cycle
    assign o_can_take = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result item
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_BYTES  = 920;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 20_000_000;

    typedef logic [7:0] t_byte_q[$];

    // ways of spoiling one sequence inside an otherwise well-formed text
    typedef enum int {
        BRK_OVERLONG,
        BRK_SURROGATE,
        BRK_ABOVE_MAX,
        BRK_BAD_CONT,
        BRK_NUL,
        BRK_BAD_LEAD
    } t_break_kind;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_final_byte = 1'b0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_has_point;
    logic [20:0] o_code_point;
    logic        o_end_of_text;
    logic        o_text_ok;

    // decoder state as predicted
    logic [1:0]  bytes_due   = 2'd0;
    logic [2:0]  seq_len     = su8d_pkg::SEQ_NONE;
    logic [20:0] partial_cp  = '0;
    logic        text_failed = 1'b0;

    su8d_pkg::t_result points_due[$];
    int      fault_count = 0;
    int      bytes_sent  = 0;
    int      rx_stall    = 0;
    bit      tx_calm     = 1'b0;
    bit      rx_calm     = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    strict_utf8_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_has_point   (o_has_point),
        .o_code_point  (o_code_point),
        .o_end_of_text (o_end_of_text),
        .o_text_ok     (o_text_ok)
    );

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // add one byte to the end of a text
    function automatic void append_byte(ref t_byte_q t, input logic [7:0] b);
        t.insert(t.size(), b);
    endfunction

    function automatic logic is_scalar_legal(input logic [2:0] len, input logic [20:0] cp);
        logic overlong;
        logic surrogate;
        overlong  = (len == su8d_pkg::SEQ_THREE && cp < su8d_pkg::MIN_THREE) ||
                    (len == su8d_pkg::SEQ_FOUR && cp < su8d_pkg::MIN_FOUR);
        surrogate = (cp >= su8d_pkg::SURR_LO) && (cp <= su8d_pkg::SURR_HI);
        return !overlong && !surrogate && (cp <= su8d_pkg::CP_MAX);
    endfunction

    // advance the predicted decoder by one byte and queue any result it gives
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        su8d_pkg::t_result res;
        logic              hp;
        logic [20:0]       cp;
        hp = 1'b0;
        cp = '0;
        if (!text_failed) begin
            if (bytes_due == 2'd0) begin
                if (b == 8'h00) begin
                    text_failed = 1'b1;
                end else if (b <= su8d_pkg::ASCII_MAX) begin
                    hp = 1'b1;
                    cp = 21'(b);
                end else if (b >= su8d_pkg::LEAD2_MIN && b <= su8d_pkg::LEAD2_MAX) begin
                    bytes_due  = 2'd1;
                    seq_len    = su8d_pkg::SEQ_TWO;
                    partial_cp = 21'(b[4:0]);
                end else if (b >= su8d_pkg::LEAD3_MIN && b < su8d_pkg::LEAD4_MIN) begin
                    bytes_due  = 2'd2;
                    seq_len    = su8d_pkg::SEQ_THREE;
                    partial_cp = 21'(b[3:0]);
                end else if (b >= su8d_pkg::LEAD4_MIN && b <= su8d_pkg::LEAD4_MAX) begin
                    bytes_due  = 2'd3;
                    seq_len    = su8d_pkg::SEQ_FOUR;
                    partial_cp = 21'(b[2:0]);
                end else begin
                    text_failed = 1'b1;
                end
            end else if (b[7:6] != su8d_pkg::CONT_TAG) begin
                text_failed = 1'b1;
            end else begin
                partial_cp = {partial_cp[14:0], b[5:0]};
                bytes_due  = bytes_due - 2'd1;
                if (bytes_due == 2'd0) begin
                    if (is_scalar_legal(seq_len, partial_cp)) begin
                        hp = 1'b1;
                        cp = partial_cp;
                    end else begin
                        text_failed = 1'b1;
                    end
                    seq_len    = su8d_pkg::SEQ_NONE;
                    partial_cp = '0;
                end
            end
        end
        // end of text: a sequence left open fails it, then all state clears
        if (fin) begin
            if (bytes_due != 2'd0) text_failed = 1'b1;
            res.has_point   = hp;
            res.code_point  = cp;
            res.end_of_text = 1'b1;
            res.text_ok     = !text_failed;
            points_due.insert(points_due.size(), res);
            bytes_due   = 2'd0;
            seq_len     = su8d_pkg::SEQ_NONE;
            partial_cp  = '0;
            text_failed = 1'b0;
        end else if (hp) begin
            res.has_point   = 1'b1;
            res.code_point  = cp;
            res.end_of_text = 1'b0;
            res.text_ok     = 1'b0;
            points_due.insert(points_due.size(), res);
        end
    endfunction

    // check each result item against the oldest prediction, and stall the output side
    always @(posedge i_clk) begin : result_check
        su8d_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (points_due.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result item: hp=%0d cp=%h eot=%0d ok=%0d",
                             o_has_point, o_code_point, o_end_of_text, o_text_ok);
            end else begin
                want = points_due.pop_front();
                if (o_has_point !== want.has_point || o_code_point !== want.code_point ||
                    o_end_of_text !== want.end_of_text || o_text_ok !== want.text_ok) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected hp=%0d cp=%h eot=%0d ok=%0d",
                                 want.has_point, want.code_point, want.end_of_text,
                                 want.text_ok);
                        $display("          got      hp=%0d cp=%h eot=%0d ok=%0d",
                                 o_has_point, o_code_point, o_end_of_text, o_text_ok);
                    end
                end
            end
        end
        if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            rx_stall = rx_calm ? 0 : random_gap();
            i_ready <= (rx_stall == 0);
        end
    end

    // send one byte; valid stays high on return unless the caller rests or gaps
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_calm ? 0 : random_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_text(input t_byte_q txt);
        for (int i = 0; i < txt.size(); i++)
            send_byte(txt[i], i == txt.size() - 1);
    endtask

    // called in the step of the last acceptance
    task automatic sender_rest();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (points_due.size() != 0);
    endtask

    function automatic void len_range(input int len, output logic [20:0] lo,
                                      output logic [20:0] hi);
        case (len)
            1: begin lo = 21'h000001; hi = 21'(su8d_pkg::ASCII_MAX); end
            2: begin lo = 21'h000080; hi = 21'h0007ff; end
            3: begin lo = su8d_pkg::MIN_THREE; hi = 21'h00ffff; end
            default: begin lo = su8d_pkg::MIN_FOUR; hi = su8d_pkg::CP_MAX; end
        endcase
    endfunction

    // a legal scalar for the given length, ends of the range favoured
    function automatic logic [20:0] pick_point(input int len);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        len_range(len, lo, hi);
        if ($urandom_range(0, 9) == 0)
            cp = $urandom_range(0, 1) ? hi : lo;
        else
            cp = 21'($urandom_range(lo, hi));
        if (cp >= su8d_pkg::SURR_LO && cp <= su8d_pkg::SURR_HI) cp = cp ^ 21'h004000;
        return cp;
    endfunction

    function automatic void encode_point(input logic [20:0] cp, input int len, ref t_byte_q t);
        case (len)
            1: append_byte(t, cp[7:0]);
            2: begin
                append_byte(t, {3'b110, cp[10:6]});
                append_byte(t, {su8d_pkg::CONT_TAG, cp[5:0]});
            end
            3: begin
                append_byte(t, {4'b1110, cp[15:12]});
                append_byte(t, {su8d_pkg::CONT_TAG, cp[11:6]});
                append_byte(t, {su8d_pkg::CONT_TAG, cp[5:0]});
            end
            default: begin
                append_byte(t, {5'b11110, cp[20:18]});
                append_byte(t, {su8d_pkg::CONT_TAG, cp[17:12]});
                append_byte(t, {su8d_pkg::CONT_TAG, cp[11:6]});
                append_byte(t, {su8d_pkg::CONT_TAG, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void append_broken(ref t_byte_q t);
        t_break_kind kind;
        int          len;
        logic [20:0] lo;
        logic [20:0] hi;
        kind = t_break_kind'($urandom_range(0, 5));
        case (kind)
            BRK_OVERLONG: begin
                len = $urandom_range(2, 4);
                len_range(len, lo, hi);
                encode_point(21'($urandom_range(0, lo - 1)), len, t);
            end
            BRK_SURROGATE: begin
                encode_point(21'($urandom_range(su8d_pkg::SURR_LO, su8d_pkg::SURR_HI)), 3, t);
            end
            BRK_ABOVE_MAX: begin
                encode_point(21'($urandom_range(su8d_pkg::CP_MAX + 1, 21'h1fffff)), 4, t);
            end
            BRK_BAD_CONT: begin
                append_byte(t, 8'($urandom_range(su8d_pkg::LEAD2_MIN, su8d_pkg::LEAD4_MAX)));
                append_byte(t, 8'($urandom_range(0, 255)));
            end
            BRK_NUL: append_byte(t, 8'h00);
            default: begin
                if ($urandom_range(0, 1))
                    append_byte(t, 8'($urandom_range(8'h80, 8'hc1)));
                else
                    append_byte(t, 8'($urandom_range(8'hf5, 8'hff)));
            end
        endcase
    endfunction

    // mostly well-formed texts, some with one spoilt sequence, some raw noise
    function automatic void build_text(ref t_byte_q t);
        int n;
        int len;
        int brk_at;
        bit broken;
        t.delete();
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) append_byte(t, 8'($urandom_range(0, 255)));
            return;
        end
        n      = $urandom_range(1, 8);
        broken = ($urandom_range(0, 3) == 0);
        brk_at = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
            if (broken && i == brk_at) begin
                append_broken(t);
            end else begin
                len = $urandom_range(1, 4);
                encode_point(pick_point(len), len, t);
            end
        end
        // cut the last sequence short now and then
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(2, 4);
            encode_point(pick_point(len), len, t);
            repeat ($urandom_range(1, len - 1)) void'(t.pop_back());
        end
    endfunction

    task automatic test_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // both one-byte bounds, smallest two- and three-byte points, largest scalar
    task automatic test_legal_forms();
        t_byte_q t;
        t = '{8'h01, 8'h7f, 8'hc2, 8'h80, 8'he0, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_text(t);
        sender_rest();
        wait_drained();
    endtask

    // texts with NUL, bad leads, overlong forms, a surrogate, a point too large
    task automatic test_rejections();
        t_byte_q t;
        t = '{8'h00};
        send_text(t);
        // bad lead, then a byte that is ignored after the failure
        t = '{8'hc1, 8'h41};
        send_text(t);
        t = '{8'hf5};
        send_text(t);
        t = '{8'he0, 8'h9f, 8'hbf};
        send_text(t);
        t = '{8'hed, 8'ha0, 8'h80};
        send_text(t);
        t = '{8'hf0, 8'h8f, 8'hbf, 8'hbf};
        send_text(t);
        t = '{8'hf4, 8'h90, 8'h80, 8'h80};
        send_text(t);
        sender_rest();
        wait_drained();
    endtask

    // lead byte where a continuation is due, and a sequence cut off at the end
    task automatic test_text_boundaries();
        t_byte_q t;
        t = '{8'hc2, 8'hc2};
        send_text(t);
        t = '{8'he2, 8'h82};
        send_text(t);
        sender_rest();
        wait_drained();
    endtask

    // sender holds off mid-stream until every result is back
    task automatic test_pause_until_drained();
        t_byte_q t;
        repeat (2) begin
            repeat (5) begin
                build_text(t);
                send_text(t);
            end
            sender_rest();
            wait_drained();
        end
    endtask

    task automatic test_random_texts();
        t_byte_q t;
        int      texts;
        int      goal;
        texts = 0;
        goal  = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < goal) begin
            // stretches without idling on one or both sides
            if (texts % 30 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm <= ($urandom_range(0, 3) == 0);
            end
            build_text(t);
            send_text(t);
            texts++;
        end
        tx_calm = 1'b0;
        rx_calm <= 1'b0;
        sender_rest();
        wait_drained();
    endtask

    initial begin
        test_reset();
        test_legal_forms();
        test_rejections();
        test_text_boundaries();
        test_pause_until_drained();
        test_random_texts();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && points_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/su8d_pkg.sv
hdl/su8d_in_reg.sv
hdl/su8d_decode.sv
hdl/su8d_out_reg.sv
hdl/strict_utf8_decoder_top.sv
tb/tb_top.sv
